>>> hdl/nec_ir_pkg.sv
`default_nettype none

package nec_ir_pkg;

  // decoder states
  typedef enum logic [3:0] {
    ST_LEADER = 4'b0001,
    ST_SPACE  = 4'b0010,
    ST_LOW    = 4'b0100,
    ST_BIT    = 4'b1000
  } nec_state_t;

  // configuration register indexes
  localparam logic CFG_REPEAT_ENABLE = 1'b0;
  localparam logic CFG_REPEAT_FILTER = 1'b1;

  localparam logic [7:0] REPEAT_FILTER_RESET = 8'd5;

  // gap in 1 us ticks at which the 10 us width saturates
  localparam logic [31:0] GAP_SAT_LIMIT = 32'd655360;
  // ceil(2^23 / 10), exact for gaps below 2^22
  localparam logic [19:0] DIV10_RECIP   = 20'd838861;

  // widths in 10 us units
  localparam logic [15:0] LEAD_A_MIN  = 16'd400;
  localparam logic [15:0] LEAD_A_MAX  = 16'd500;
  localparam logic [15:0] LEAD_B_MIN  = 16'd700;
  localparam logic [15:0] LEAD_B_MAX  = 16'd1100;
  localparam logic [15:0] SPACE_MIN   = 16'd313;
  localparam logic [15:0] SPACE_MAX   = 16'd600;
  localparam logic [15:0] REPEAT_MIN  = 16'd150;
  localparam logic [15:0] REPEAT_MAX  = 16'd250;
  localparam logic [15:0] LOW_MIN     = 16'd10;
  localparam logic [15:0] LOW_MAX     = 16'd100;
  localparam logic [16:0] ZERO_MIN    = 17'd92;
  localparam logic [16:0] ZERO_MAX    = 17'd132;
  localparam logic [16:0] ONE_MIN     = 17'd205;
  localparam logic [16:0] ONE_MAX     = 17'd245;

  localparam logic [7:0] BIT_ONE      = 8'h80;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_FRAME  = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;

  function automatic logic is_leader(input logic [15:0] w);
    is_leader = (w > LEAD_A_MIN && w < LEAD_A_MAX) || (w > LEAD_B_MIN && w < LEAD_B_MAX);
  endfunction

endpackage

`default_nettype wire

>>> hdl/nec_ir_pulse_decoder.sv
// NEC infrared remote decoder driven by edge timestamps.
// s_axis carries one 32-bit capture of a free-running 1 MHz counter per
// transfer, taken at each edge of the receiver output. Every input transfer
// gives exactly one output transfer on m_axis: tuser holds the event code
// (none, frame complete, repeat key) and tdata the four received bytes, the
// checksum flag and the measured gap in 10 us units (saturated at 65535).
// cfg_we writes repeat_enable (index 0) or repeat_filter (index 1); write
// only while no transfer is in flight.
// Four register stages: input, gap, width (multiply by the reciprocal of
// ten), decoder with result register. An accepted transfer moves through
// them to m_axis; with m_tready high one transfer is taken every cycle.
// When m_tready is low the stages fill up and s_tready falls once all four
// hold data; nothing is dropped. Reset (rst, synchronous) empties the
// stages, returns the decoder to the leader search, clears the bytes and
// the repeat counter, and the first capture after reset only seeds the
// stored timestamp.
`default_nettype none

module nec_ir_pulse_decoder
  import nec_ir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // capture_time
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // addr_low, addr_high, command, command_inv,
                                           // checksum_ok, pulse_width, zero fill
  output logic [1:0]       m_axis_tuser,   // event_res
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  logic        repeat_enable;
  logic [7:0]  repeat_filter;

  logic        in_v;
  logic [31:0] in_time;

  logic        g_v;
  logic        g_first;
  logic        g_sat;
  logic [19:0] g_low;
  logic [31:0] last_capture;
  logic        seeded;

  logic        w_v;
  logic        w_first;
  logic [15:0] w;

  logic        o_v;
  logic [1:0]  o_event;
  logic [15:0] o_width;

  nec_state_t  state, state_next;
  logic [6:0]  low_width, low_width_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [5:0]  bit_count, bit_count_next;
  logic [7:0]  rx_bytes [4];
  logic [7:0]  rx_bytes_next [4];
  logic [7:0]  repeat_count, repeat_count_next;
  logic [1:0]  event_next;

  logic        out_ready, w_ready, g_ready, in_ready;
  logic [31:0] gap;
  logic [39:0] prod;
  logic [16:0] total;
  logic [7:0]  shifted;
  logic [5:0]  bc_inc;

  assign out_ready     = !o_v || m_axis_tready;
  assign w_ready       = !w_v || out_ready;
  assign g_ready       = !g_v || w_ready;
  assign in_ready      = !in_v || g_ready;
  assign s_axis_tready = in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable <= 1'b0;
      repeat_filter <= REPEAT_FILTER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_REPEAT_ENABLE: repeat_enable <= cfg_wdata[0];
        CFG_REPEAT_FILTER: repeat_filter <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= s_axis_tvalid;
    end
    if (s_axis_tvalid && in_ready) begin
      in_time <= s_axis_tdata;
    end
  end

  // gap stage, wrap counts one tick short
  always_comb begin
    gap = in_time - last_capture;
    if (in_time < last_capture) begin
      gap = gap - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v          <= 1'b0;
      seeded       <= 1'b0;
      last_capture <= '0;
    end else begin
      if (g_ready) begin
        g_v <= in_v;
      end
      if (in_v && g_ready) begin
        seeded       <= 1'b1;
        last_capture <= in_time;
      end
    end
    if (in_v && g_ready) begin
      g_first <= !seeded;
      g_sat   <= gap >= GAP_SAT_LIMIT;
      g_low   <= gap[19:0];
    end
  end

  // width stage, divide by ten
  assign prod = 40'(g_low) * 40'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else if (w_ready) begin
      w_v <= g_v;
    end
    if (g_v && w_ready) begin
      w_first <= g_first;
      if (g_first) begin
        w <= '0;
      end else if (g_sat) begin
        w <= 16'hFFFF;
      end else begin
        w <= prod[38:23];
      end
    end
  end

  // decoder
  assign total   = 17'(low_width) + 17'(w);
  assign shifted = shift_byte >> 1;
  assign bc_inc  = bit_count + 6'd1;

  always_comb begin
    state_next        = state;
    low_width_next    = low_width;
    shift_byte_next   = shift_byte;
    bit_count_next    = bit_count;
    repeat_count_next = repeat_count;
    event_next        = EV_NONE;
    for (int i = 0; i < 4; i++) begin
      rx_bytes_next[i] = rx_bytes[i];
    end
    case (state)
      ST_LEADER: begin
        if (is_leader(w)) begin
          state_next      = ST_SPACE;
          shift_byte_next = '0;
          bit_count_next  = '0;
        end
      end
      ST_SPACE: begin
        state_next = ST_LEADER;
        if (w > SPACE_MIN && w < SPACE_MAX) begin
          state_next = ST_LOW;
        end else if (w > REPEAT_MIN && w < REPEAT_MAX && repeat_enable) begin
          if (repeat_count >= repeat_filter) begin
            event_next = EV_REPEAT;
          end else begin
            repeat_count_next = repeat_count + 8'd1;
          end
        end
      end
      ST_LOW: begin
        if (w > LOW_MIN && w < LOW_MAX) begin
          state_next     = ST_BIT;
          low_width_next = w[6:0];
        end else begin
          state_next = ST_LEADER;
          if (is_leader(w)) begin
            state_next      = ST_SPACE;
            shift_byte_next = '0;
            bit_count_next  = '0;
          end
        end
      end
      ST_BIT: begin
        shift_byte_next = shifted;
        if ((total > ZERO_MIN && total < ZERO_MAX) || (total > ONE_MIN && total < ONE_MAX)) begin
          if (total > ONE_MIN && total < ONE_MAX) begin
            shift_byte_next = shifted + BIT_ONE;
          end
          bit_count_next = bc_inc;
          state_next     = ST_LOW;
          if (bc_inc == 6'd8 || bc_inc == 6'd16 || bc_inc == 6'd24) begin
            rx_bytes_next[bc_inc[4:3] - 2'd1] = shift_byte_next;
            shift_byte_next = '0;
          end else if (bc_inc == 6'd32) begin
            rx_bytes_next[3] = shift_byte_next;
            if (rx_bytes[2] == ~shift_byte_next) begin
              repeat_count_next = '0;
            end
            state_next = ST_LEADER;
            event_next = EV_FRAME;
          end
        end else begin
          state_next = ST_LEADER;
          if (is_leader(w)) begin
            state_next      = ST_SPACE;
            shift_byte_next = '0;
            bit_count_next  = '0;
          end
        end
      end
      default: begin
        state_next = ST_LEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v          <= 1'b0;
      state        <= ST_LEADER;
      low_width    <= '0;
      shift_byte   <= '0;
      bit_count    <= '0;
      repeat_count <= '0;
      for (int i = 0; i < 4; i++) begin
        rx_bytes[i] <= '0;
      end
    end else begin
      if (out_ready) begin
        o_v <= w_v;
      end
      if (w_v && out_ready && !w_first) begin
        state        <= state_next;
        low_width    <= low_width_next;
        shift_byte   <= shift_byte_next;
        bit_count    <= bit_count_next;
        repeat_count <= repeat_count_next;
        for (int i = 0; i < 4; i++) begin
          rx_bytes[i] <= rx_bytes_next[i];
        end
      end
    end
    if (w_v && out_ready) begin
      o_event <= w_first ? EV_NONE : event_next;
      o_width <= w;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tuser  = o_event;
  assign m_axis_tdata  = {7'd0, o_width, (rx_bytes[2] == ~rx_bytes[3]),
                          rx_bytes[3], rx_bytes[2], rx_bytes[1], rx_bytes[0]};

endmodule

`default_nettype wire

>>> verif/nec_ir_pulse_decoder_tb.sv
`timescale 1ns / 100ps

module nec_ir_pulse_decoder_tb
  import nec_ir_pkg::*;
();

  typedef struct packed {
    logic [1:0]  event_code;
    logic [7:0]  addr_low;
    logic [7:0]  addr_high;
    logic [7:0]  command;
    logic [7:0]  command_inv;
    logic        checksum_ok;
    logic [15:0] pulse_width;
  } nec_event_t;

  class nec_decode_scoreboard;
    bit         repeat_on;
    bit  [7:0]  repeat_swallow;
    bit  [31:0] prev_capture;
    bit         seeded;
    nec_state_t dec_state;
    bit  [6:0]  low_part;
    bit  [7:0]  shift_reg;
    bit  [5:0]  bits_seen;
    bit  [7:0]  rx_byte [4];
    bit  [7:0]  repeats_seen;
    nec_event_t expected_events [$];
    int         failures;

    function new();
      repeat_swallow = REPEAT_FILTER_RESET;
      dec_state = ST_LEADER;
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == CFG_REPEAT_ENABLE) begin
        repeat_on = value[0];
      end else begin
        repeat_swallow = value;
      end
    endfunction

    function void retest_leader(bit [15:0] w);
      dec_state = ST_LEADER;
      if ((w > 400 && w < 500) || (w > 700 && w < 1100)) begin
        dec_state = ST_SPACE;
        shift_reg = '0;
        bits_seen = '0;
      end
    endfunction

    function bit [1:0] decode_width(bit [15:0] w);
      bit [16:0] total;
      bit [1:0]  ev;
      ev = EV_NONE;
      case (dec_state)
        ST_LEADER: retest_leader(w);
        ST_SPACE: begin
          if (w > 313 && w < 600) begin
            dec_state = ST_LOW;
          end else begin
            if (w > 150 && w < 250 && repeat_on) begin
              if (repeats_seen >= repeat_swallow) begin
                ev = EV_REPEAT;
              end else begin
                repeats_seen++;
              end
            end
            dec_state = ST_LEADER;
          end
        end
        ST_LOW: begin
          if (w > 10 && w < 100) begin
            dec_state = ST_BIT;
            low_part = w[6:0];
          end else begin
            retest_leader(w);
          end
        end
        default: begin
          // low and high time summed at full width
          total = {10'd0, low_part} + {1'b0, w};
          shift_reg = shift_reg >> 1;
          if (total > 205 && total < 245) begin
            shift_reg[7] = 1'b1;
          end else if (!(total > 92 && total < 132)) begin
            retest_leader(w);
            return ev;
          end
          bits_seen++;
          if (bits_seen == 6'd32) begin
            rx_byte[3] = shift_reg;
            if ({1'b0, rx_byte[2]} + rx_byte[3] == 9'd255) begin
              repeats_seen = '0;
            end
            dec_state = ST_LEADER;
            ev = EV_FRAME;
          end else begin
            if (bits_seen[2:0] == 3'd0) begin
              rx_byte[bits_seen[4:3] - 2'd1] = shift_reg;
              shift_reg = '0;
            end
            dec_state = ST_LOW;
          end
        end
      endcase
      return ev;
    endfunction

    function void note_capture(bit [31:0] now);
      bit [31:0]  gap;
      nec_event_t want;
      if (now >= prev_capture) begin
        gap = now - prev_capture;
      end else begin
        gap = 32'hFFFF_FFFF - prev_capture + now;
      end
      gap = gap / 10;
      want = '0;
      // first capture after reset only seeds the timestamp
      if (seeded) begin
        want.pulse_width = (gap > 65535) ? 16'hFFFF : gap[15:0];
        want.event_code = decode_width(want.pulse_width);
      end
      seeded = 1'b1;
      prev_capture = now;
      want.addr_low = rx_byte[0];
      want.addr_high = rx_byte[1];
      want.command = rx_byte[2];
      want.command_inv = rx_byte[3];
      want.checksum_ok = ({1'b0, rx_byte[2]} + rx_byte[3] == 9'd255);
      expected_events.push_back(want);
    endfunction

    function void check_event(logic [1:0] user, logic [55:0] data);
      nec_event_t got;
      nec_event_t want;
      got.event_code = user;
      got.addr_low = data[7:0];
      got.addr_high = data[15:8];
      got.command = data[23:16];
      got.command_inv = data[31:24];
      got.checksum_ok = data[32];
      got.pulse_width = data[48:33];
      if (expected_events.size() == 0) begin
        if (failures < 10) begin
          $display("%0t: unexpected transfer, tuser %0d tdata %h", $time, user, data);
        end
        failures++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_code !== want.event_code || got.addr_low !== want.addr_low ||
          got.addr_high !== want.addr_high || got.command !== want.command ||
          got.command_inv !== want.command_inv || got.checksum_ok !== want.checksum_ok ||
          got.pulse_width !== want.pulse_width) begin
        if (failures < 10) begin
          $display("%0t: mismatch, expected ev %0d bytes %h %h %h %h ok %0d width %0d",
                   $time, want.event_code, want.addr_low, want.addr_high, want.command,
                   want.command_inv, want.checksum_ok, want.pulse_width);
          $display("%0t:           actual   ev %0d bytes %h %h %h %h ok %0d width %0d",
                   $time, got.event_code, got.addr_low, got.addr_high, got.command,
                   got.command_inv, got.checksum_ok, got.pulse_width);
        end
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  nec_decode_scoreboard tracker;
  bit          sender_idle;
  bit          receiver_idle;
  bit          hold_request;
  bit   [31:0] clock_now;
  int unsigned captures_sent;

  always #10 clk = ~clk;

  nec_ir_pulse_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  task automatic send_capture(input logic [31:0] value);
    int pick;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_capture(value);
    captures_sent++;
    pick = $urandom_range(0, 99);
    if (sender_idle && pick >= 70) begin
      s_axis_tvalid <= 1'b0;
      repeat ((pick >= 96) ? $urandom_range(8, 30) : $urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic emit_at(input logic [31:0] value);
    clock_now = value;
    send_capture(value);
  endtask

  task automatic emit_ticks(input int unsigned ticks);
    clock_now += ticks;
    send_capture(clock_now);
  endtask

  task automatic send_leader();
    if ($urandom_range(0, 1)) begin
      emit_ticks($urandom_range(4020, 4980));
    end else begin
      emit_ticks($urandom_range(7020, 10980));
    end
  endtask

  task automatic send_frame(input logic [7:0] a_lo, input logic [7:0] a_hi,
                            input logic [7:0] cmd, input logic [7:0] cmd_inv,
                            input int bit_total);
    logic [31:0] payload;
    int          lw;
    int          target;
    payload = {cmd_inv, cmd, a_hi, a_lo};
    send_leader();
    emit_ticks($urandom_range(3150, 5980));
    for (int i = 0; i < bit_total; i++) begin
      lw = $urandom_range(12, 90);
      target = payload[i] ? $urandom_range(207, 243) : $urandom_range(94, 130);
      emit_ticks(lw * 10 + $urandom_range(2, 8));
      emit_ticks((target - lw) * 10 + $urandom_range(2, 8));
    end
  endtask

  task automatic send_random_sequence();
    int         pick;
    logic [7:0] cmd;
    pick = $urandom_range(0, 99);
    cmd = 8'($urandom);
    if (pick < 40) begin
      send_frame(8'($urandom), 8'($urandom), cmd,
                 ($urandom_range(0, 3) != 0) ? ~cmd : 8'($urandom), 32);
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 6)) begin
        send_leader();
        emit_ticks($urandom_range(1520, 2480));
      end
    end else if (pick < 75) begin
      // frame cut short by a stray width
      send_frame(8'($urandom), 8'($urandom), cmd, ~cmd, $urandom_range(0, 31));
      emit_ticks($urandom_range(0, 12000));
    end else if (pick < 88) begin
      emit_ticks($urandom_range(0, 12000));
    end else if (pick < 93) begin
      emit_at($urandom);
    end else if (pick < 97) begin
      emit_ticks($urandom_range(655370, 2000000));
    end else begin
      emit_at(32'hFFFF_FFFF - $urandom_range(0, 20000));
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int pick;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        tracker.check_event(m_axis_tuser, m_axis_tdata);
      end
      pick = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (receiver_idle && pick >= 75) begin
        stall_left = (pick >= 96) ? $urandom_range(9, 24) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit       enable_list [5];
    bit [7:0] filter_list [5];
    int unsigned phase_start;
    enable_list = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    filter_list = '{8'd0, 8'd3, 8'd255, 8'd255, 8'd1};
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // seed, then a small step up to the top of the counter
    emit_at(32'hFFFF_FFF0);
    emit_at(32'hFFFF_FFFF);
    // counter wrap into a leader, then a repeat gap with reporting off
    emit_at(32'h0000_2328);
    emit_ticks(2250);
    // zero width, then a capture below the last one saturates
    emit_ticks(0);
    emit_at(32'h0000_0000);
    // bit sum that would alias into the zero window if it wrapped
    emit_ticks(9000);
    emit_ticks(4500);
    emit_ticks(995);
    emit_ticks(700000);
    // bad bit width that is itself a leader
    emit_ticks(4500);
    emit_ticks(4500);
    emit_ticks(560);
    emit_ticks(9000);
    // bad low width that is itself a leader
    emit_ticks(4500);
    emit_ticks(9000);
    emit_ticks(20);
    emit_at(clock_now - 1);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_register(CFG_REPEAT_ENABLE, {7'd0, enable_list[p]});
      write_register(CFG_REPEAT_FILTER, filter_list[p]);
      sender_idle = (p != 0);
      receiver_idle = (p != 0);
      phase_start = captures_sent;
      if (p == 1) begin
        // sink holds off at the start of a whole frame offered back to back
        sender_idle = 1'b0;
        hold_request = 1'b1;
        send_frame(8'($urandom), 8'($urandom), 8'h5A, 8'hA5, 32);
        sender_idle = 1'b1;
      end
      while (captures_sent - phase_start < 200) send_random_sequence();
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (tracker.failures == 0 && tracker.expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> nec_ir_pulse_decoder.f
hdl/nec_ir_pkg.sv
hdl/nec_ir_pulse_decoder.sv
verif/nec_ir_pulse_decoder_tb.sv
